[design/qarm_pkg.sv]
// shared constants, register indexes and helper functions for the quad attitude rate mixer
// used by qarm_div and quad_attitude_rate_mixer_core; depends on nothing
`default_nettype none

package qarm_pkg;

    // default fixed point fraction width
    localparam int FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int GAIN_W     = 31;

    localparam logic [CFG_IDX_W-1:0] REG_BANK_GAIN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MGAIN_X      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MGAIN_Y      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MGAIN_Z      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS     = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_SCALE    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_SCALE   = 8'd7;

    localparam logic [GAIN_W-1:0] GAIN_RST_ZERO = 31'd0;
    localparam logic [GAIN_W-1:0] GAIN_RST_ONE  = 31'd65536;

    // pipelined divider: quotient bits retired per stage
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = 32 / DIV_STEP;
    localparam int DIV_LAT    = DIV_STAGES + 2;

    // heading cordic
    localparam int    CORDIC_ITERS = 24;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // round a q30 angle to the working fraction width
    function automatic longint f_q30_to_frac(input longint v, input int frac);
        return (v + (longint'(1) <<< (29 - frac))) >>> (30 - frac);
    endfunction

    // arctangent of 2^-i in q30
    function automatic longint f_atan_q30(input int i);
        unique case (i)
            0:       return 64'sd843314857;
            1:       return 64'sd497837829;
            2:       return 64'sd263043837;
            3:       return 64'sd133525159;
            4:       return 64'sd67021687;
            5:       return 64'sd33543516;
            6:       return 64'sd16775851;
            7:       return 64'sd8388437;
            8:       return 64'sd4194283;
            9:       return 64'sd2097149;
            10:      return 64'sd1048576;
            default: return longint'(1) <<< (30 - i);
        endcase
    endfunction

endpackage

`default_nettype wire

[design/qarm_div.sv]
// pipelined signed fixed point divider, (num * 2^frac) / den, truncated and saturated
// restoring division, DIV_STEP quotient bits per stage; depends on qarm_pkg
`default_nettype none

module qarm_div #(
    parameter int FRAC_BITS = qarm_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic signed [31:0] o_quo
);
    import qarm_pkg::*;

    localparam int HI_SHIFT = 32 - FRAC_BITS;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
    } t_div_acc;

    t_div_acc    r_acc [0:DIV_STAGES];
    logic [31:0] r_den [0:DIV_STAGES];
    logic        r_neg [0:DIV_STAGES];
    logic        r_ovf [0:DIV_STAGES];
    logic        r_dz  [0:DIV_STAGES];
    logic signed [31:0] r_out;

    logic [32:0] n_num_mag;
    logic [32:0] n_den_mag;
    logic [31:0] n_hi;

    function automatic t_div_acc f_step(input t_div_acc a, input logic [31:0] d);
        t_div_acc    t;
        logic [32:0] r;
        t = a;
        for (int u = 0; u < DIV_STEP; u++) begin
            r     = {t.rem[31:0], t.low[31]};
            t.low = {t.low[30:0], 1'b0};
            if (r >= {1'b0, d}) begin
                r     = r - {1'b0, d};
                t.quo = {t.quo[30:0], 1'b1};
            end else begin
                t.quo = {t.quo[30:0], 1'b0};
            end
            t.rem = r;
        end
        return t;
    endfunction

    // magnitudes, high part of the shifted dividend
    always_comb begin
        n_num_mag = i_num[31] ? (33'd0 - 33'(i_num)) : 33'(i_num);
        n_den_mag = i_den[31] ? (33'd0 - 33'(i_den)) : 33'(i_den);
        n_hi      = n_num_mag[31:0] >> HI_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        r_acc[0].rem <= {1'b0, n_hi};
        r_acc[0].low <= n_num_mag[31:0] << FRAC_BITS;
        r_acc[0].quo <= '0;
        r_den[0]     <= n_den_mag[31:0];
        r_neg[0]     <= i_num[31] ^ i_den[31];
        // quotient needs more than 32 bits
        r_ovf[0]     <= (n_hi >= n_den_mag[31:0]);
        r_dz[0]      <= (i_den == '0);
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_acc[g+1] <= f_step(r_acc[g], r_den[g]);
            r_den[g+1] <= r_den[g];
            r_neg[g+1] <= r_neg[g];
            r_ovf[g+1] <= r_ovf[g];
            r_dz[g+1]  <= r_dz[g];
        end
    end

    // zero divisor, sign and saturation
    always_ff @(posedge i_clk) begin
        if (r_dz[DIV_STAGES]) begin
            r_out <= '0;
        end else if (r_ovf[DIV_STAGES]) begin
            r_out <= r_neg[DIV_STAGES] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (r_neg[DIV_STAGES]) begin
            if (r_acc[DIV_STAGES].quo > 32'h8000_0000) begin
                r_out <= 32'sh8000_0000;
            end else begin
                r_out <= 32'(33'd0 - {1'b0, r_acc[DIV_STAGES].quo});
            end
        end else begin
            r_out <= r_acc[DIV_STAGES].quo[31] ? 32'sh7FFF_FFFF
                                               : $signed(r_acc[DIV_STAGES].quo);
        end
    end

    assign o_quo = r_out;

endmodule

`default_nettype wire

[design/quad_attitude_rate_mixer_core.sv]
// quadrotor attitude and body rate controller with x-frame motor mixer, fixed point
// top level; depends on qarm_pkg and qarm_div
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-----------------------------------
//  command   | start, busy, i_accel_*, i_coll_thrust,  | taken when start high, busy low
//            | i_quat_*, i_rate_*, i_yaw_target        |
//  result    | o_done, o_thrust_*, o_divide_fault      | o_done strobe, one cycle, no stall
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index,  | written when valid and ready high
//            | i_cfg_data                              |
//
//  one transaction per clock; each result appears at stage LAT after its command
//  the latency is set by the two serial pipelined dividers on the rate command path
//  busy is always low and the pipeline never stalls, since the receiver takes every result
//  synchronous active low reset clears the valid bits and resets the configuration registers
//  a write index beyond the register list is ignored; data bit 31 is ignored
`default_nettype none

module quad_attitude_rate_mixer_core #(
    parameter int FRAC_BITS = qarm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command
    input  logic                              start,
    output logic                              busy,
    input  logic signed [31:0]                i_accel_x_cmd,
    input  logic signed [31:0]                i_accel_y_cmd,
    input  logic signed [31:0]                i_coll_thrust,
    input  logic signed [31:0]                i_quat_w,
    input  logic signed [31:0]                i_quat_x,
    input  logic signed [31:0]                i_quat_y,
    input  logic signed [31:0]                i_quat_z,
    input  logic signed [31:0]                i_rate_p,
    input  logic signed [31:0]                i_rate_q,
    input  logic signed [31:0]                i_rate_r,
    input  logic signed [31:0]                i_yaw_target,
    // result
    output logic                              o_done,
    output logic signed [31:0]                o_thrust_front_left,
    output logic signed [31:0]                o_thrust_front_right,
    output logic signed [31:0]                o_thrust_rear_left,
    output logic signed [31:0]                o_thrust_rear_right,
    output logic                              o_divide_fault,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qarm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qarm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import qarm_pkg::*;

    // stage map: the command registers at stage 1, the result at stage LAT
    localparam int S_Q1  = 2 + DIV_LAT;        // first quotient (lateral / collective)
    localparam int S_NUM = S_Q1 + 4;           // numerators of the body rate commands
    localparam int S_Q2  = S_NUM + DIV_LAT;    // body rate commands
    localparam int S_MIX = S_Q2 + 3;           // moments ready for the mixer
    localparam int LAT   = S_MIX + 1;

    // heading path: pre-rotation at stage 3, cordic, then remainder stages
    localparam int S_CZ    = 3 + CORDIC_ITERS;
    localparam int S_ERR   = S_CZ + 1;
    localparam int MOD_ST  = S_MIX - 5 - S_ERR; // remainder stages
    localparam int S_MOD   = S_ERR + MOD_ST;
    localparam int NMOD    = 32 - FRAC_BITS;    // shifted multiples of 2*pi tried
    localparam int MOD_PER = (NMOD + MOD_ST - 1) / MOD_ST; // remainder steps per stage

    localparam logic signed [63:0] ONE       = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] HALF_PI_F = 32'(f_q30_to_frac(HALF_PI_Q30, FRAC_BITS));
    localparam longint             TWO_PI_F  = f_q30_to_frac(TWO_PI_Q30, FRAC_BITS);

    // configuration registers
    logic [GAIN_W-1:0] r_bank_gain;
    logic [GAIN_W-1:0] r_heading_gain;
    logic [GAIN_W-1:0] r_mgain_x;
    logic [GAIN_W-1:0] r_mgain_y;
    logic [GAIN_W-1:0] r_mgain_z;
    logic [GAIN_W-1:0] r_inv_mass;
    logic [GAIN_W-1:0] r_arm_scale;
    logic [GAIN_W-1:0] r_drag_scale;

    logic signed [31:0] w_bank_gain;
    logic signed [31:0] w_heading_gain;
    logic signed [31:0] w_mgain_x;
    logic signed [31:0] w_mgain_y;
    logic signed [31:0] w_mgain_z;
    logic signed [31:0] w_inv_mass;
    logic signed [31:0] w_arm_scale;
    logic signed [31:0] w_drag_scale;

    // valid bits
    logic r_vld [1:LAT];

    // delay lines, element k holds the value at stage k
    logic signed [31:0] r_ax_p   [1:2];
    logic signed [31:0] r_ay_p   [1:2];
    logic signed [31:0] r_cacc_p [1:2];
    logic signed [31:0] r_thr_p  [1:S_MIX];
    logic signed [31:0] r_rp_p   [1:S_Q2];
    logic signed [31:0] r_rq_p   [1:S_Q2];
    logic signed [31:0] r_rr_p   [1:S_MOD+2];
    logic signed [31:0] r_ytgt_p [1:S_CZ];
    logic signed [31:0] r_r02_p  [2:S_Q1];
    logic signed [31:0] r_r12_p  [2:S_Q1];
    logic signed [31:0] r_r00_p  [2:S_Q1+2];
    logic signed [31:0] r_r01_p  [2:S_Q1+2];
    logic signed [31:0] r_r10_p  [2:S_Q1+2];
    logic signed [31:0] r_r11_p  [2:S_Q1+2];
    logic signed [31:0] r_r22_p  [2:S_NUM];
    logic               r_flt_p  [2:S_MIX];

    // stage 1 quaternion products
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [31:0] n_xx, n_yy, n_zz, n_xy, n_xz, n_yz, n_wx, n_wy, n_wz, n_cacc;

    // stage 2 rotation matrix
    logic signed [31:0] n_r00, n_r01, n_r02, n_r10, n_r11, n_r12, n_r22;
    logic               n_flt;

    // rate command path
    logic signed [31:0] w_q1x, w_q1y, w_pc, w_qc;
    logic signed [31:0] r_ex, r_ey, r_bx, r_by;
    logic signed [31:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [31:0] r_nump, r_numq;
    logic signed [31:0] r_pe, r_qe, r_mx, r_my, r_mp, r_mq;

    // heading path
    logic signed [35:0] r_cx  [3:S_CZ];
    logic signed [35:0] r_cy  [3:S_CZ];
    logic signed [31:0] r_cz  [3:S_CZ];
    logic               r_cnz [3:S_CZ];
    logic signed [35:0] n_cx, n_cy;
    logic signed [31:0] n_cz;
    logic signed [31:0] w_yaw;
    logic signed [33:0] n_err;
    logic [32:0]        r_mm [S_ERR:S_MOD];
    logic               r_ms [S_ERR:S_MOD];
    logic signed [31:0] w_rem_mag;
    logic signed [31:0] r_rem, r_yc, r_ye, r_mz, r_mr;

    // mixer
    logic signed [33:0] n_sum_fl, n_sum_fr, n_sum_rl, n_sum_rr;
    logic signed [31:0] r_tfl, r_tfr, r_trl, r_trr;
    logic               r_fault;

    function automatic logic signed [31:0] f_mulq(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return f_sat32(p >>> FRAC_BITS);
    endfunction

    // restoring steps of the remainder by 2*pi, MOD_PER of them per stage
    function automatic logic [32:0] f_mod_stage(input logic [32:0] m, input int j);
        logic [35:0] t;
        logic [35:0] c;
        int          s;
        t = 36'(m);
        for (int u = 0; u < MOD_PER; u++) begin
            s = MOD_PER * j + u;
            if (s < NMOD) begin
                c = 36'(TWO_PI_F) << (NMOD - 1 - s);
                if (t >= c) begin
                    t = t - c;
                end
            end
        end
        return t[32:0];
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign w_bank_gain    = $signed({1'b0, r_bank_gain});
    assign w_heading_gain = $signed({1'b0, r_heading_gain});
    assign w_mgain_x      = $signed({1'b0, r_mgain_x});
    assign w_mgain_y      = $signed({1'b0, r_mgain_y});
    assign w_mgain_z      = $signed({1'b0, r_mgain_z});
    assign w_inv_mass     = $signed({1'b0, r_inv_mass});
    assign w_arm_scale    = $signed({1'b0, r_arm_scale});
    assign w_drag_scale   = $signed({1'b0, r_drag_scale});

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_bank_gain    <= GAIN_RST_ZERO;
            r_heading_gain <= GAIN_RST_ZERO;
            r_mgain_x      <= GAIN_RST_ZERO;
            r_mgain_y      <= GAIN_RST_ZERO;
            r_mgain_z      <= GAIN_RST_ZERO;
            r_inv_mass     <= GAIN_RST_ONE;
            r_arm_scale    <= GAIN_RST_ONE;
            r_drag_scale   <= GAIN_RST_ONE;
        end else begin
            r_vld[1] <= start && !busy;
            for (int k = 2; k <= LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_BANK_GAIN:    r_bank_gain    <= i_cfg_data[GAIN_W-1:0];
                    REG_HEADING_GAIN: r_heading_gain <= i_cfg_data[GAIN_W-1:0];
                    REG_MGAIN_X:      r_mgain_x      <= i_cfg_data[GAIN_W-1:0];
                    REG_MGAIN_Y:      r_mgain_y      <= i_cfg_data[GAIN_W-1:0];
                    REG_MGAIN_Z:      r_mgain_z      <= i_cfg_data[GAIN_W-1:0];
                    REG_INV_MASS:     r_inv_mass     <= i_cfg_data[GAIN_W-1:0];
                    REG_ARM_SCALE:    r_arm_scale    <= i_cfg_data[GAIN_W-1:0];
                    REG_DRAG_SCALE:   r_drag_scale   <= i_cfg_data[GAIN_W-1:0];
                    default: ; // unknown index, write dropped
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- stages 1 and 2
    // nine quaternion products and the collective acceleration
    always_comb begin
        n_xx   = f_mulq(i_quat_x, i_quat_x);
        n_yy   = f_mulq(i_quat_y, i_quat_y);
        n_zz   = f_mulq(i_quat_z, i_quat_z);
        n_xy   = f_mulq(i_quat_x, i_quat_y);
        n_xz   = f_mulq(i_quat_x, i_quat_z);
        n_yz   = f_mulq(i_quat_y, i_quat_z);
        n_wx   = f_mulq(i_quat_w, i_quat_x);
        n_wy   = f_mulq(i_quat_w, i_quat_y);
        n_wz   = f_mulq(i_quat_w, i_quat_z);
        n_cacc = f_sat32(64'sd0 - 64'(f_mulq(i_coll_thrust, w_inv_mass)));
    end

    // rotation matrix entries, quaternion left unnormalised
    always_comb begin
        n_r00 = f_sat32(ONE - 64'sd2 * (64'(r_yy) + 64'(r_zz)));
        n_r01 = f_sat32(64'sd2 * (64'(r_xy) - 64'(r_wz)));
        n_r02 = f_sat32(64'sd2 * (64'(r_xz) + 64'(r_wy)));
        n_r10 = f_sat32(64'sd2 * (64'(r_xy) + 64'(r_wz)));
        n_r11 = f_sat32(ONE - 64'sd2 * (64'(r_xx) + 64'(r_zz)));
        n_r12 = f_sat32(64'sd2 * (64'(r_yz) - 64'(r_wx)));
        n_r22 = f_sat32(ONE - 64'sd2 * (64'(r_xx) + 64'(r_yy)));
        // either divisor zero forces a zero result
        n_flt = (r_cacc_p[1] == '0) || (n_r22 == '0);
    end

    always_ff @(posedge i_clk) begin
        // stage 1
        r_xx        <= n_xx;
        r_yy        <= n_yy;
        r_zz        <= n_zz;
        r_xy        <= n_xy;
        r_xz        <= n_xz;
        r_yz        <= n_yz;
        r_wx        <= n_wx;
        r_wy        <= n_wy;
        r_wz        <= n_wz;
        r_cacc_p[1] <= n_cacc;
        r_ax_p[1]   <= i_accel_x_cmd;
        r_ay_p[1]   <= i_accel_y_cmd;
        r_thr_p[1]  <= i_coll_thrust;
        r_rp_p[1]   <= i_rate_p;
        r_rq_p[1]   <= i_rate_q;
        r_rr_p[1]   <= i_rate_r;
        r_ytgt_p[1] <= i_yaw_target;
        // stage 2
        r_cacc_p[2] <= r_cacc_p[1];
        r_ax_p[2]   <= r_ax_p[1];
        r_ay_p[2]   <= r_ay_p[1];
        r_r00_p[2]  <= n_r00;
        r_r01_p[2]  <= n_r01;
        r_r02_p[2]  <= n_r02;
        r_r10_p[2]  <= n_r10;
        r_r11_p[2]  <= n_r11;
        r_r12_p[2]  <= n_r12;
        r_r22_p[2]  <= n_r22;
        r_flt_p[2]  <= n_flt;
        // delay lines
        for (int k = 2; k <= S_MIX; k++) begin
            r_thr_p[k] <= r_thr_p[k-1];
        end
        for (int k = 2; k <= S_Q2; k++) begin
            r_rp_p[k] <= r_rp_p[k-1];
            r_rq_p[k] <= r_rq_p[k-1];
        end
        // yaw rate is delayed to meet the yaw rate command after the remainder
        for (int k = 2; k <= S_MOD + 2; k++) begin
            r_rr_p[k] <= r_rr_p[k-1];
        end
        for (int k = 2; k <= S_CZ; k++) begin
            r_ytgt_p[k] <= r_ytgt_p[k-1];
        end
        for (int k = 3; k <= S_Q1; k++) begin
            r_r02_p[k] <= r_r02_p[k-1];
            r_r12_p[k] <= r_r12_p[k-1];
        end
        for (int k = 3; k <= S_Q1 + 2; k++) begin
            r_r00_p[k] <= r_r00_p[k-1];
            r_r01_p[k] <= r_r01_p[k-1];
            r_r10_p[k] <= r_r10_p[k-1];
            r_r11_p[k] <= r_r11_p[k-1];
        end
        for (int k = 3; k <= S_NUM; k++) begin
            r_r22_p[k] <= r_r22_p[k-1];
        end
        for (int k = 3; k <= S_MIX; k++) begin
            r_flt_p[k] <= r_flt_p[k-1];
        end
    end

    // ---------------------------------------------------------------- roll and pitch rate path
    // lateral command over collective acceleration
    qarm_div #(.FRAC_BITS(FRAC_BITS)) u_div_ax (
        .i_clk (i_clk),
        .i_num (r_ax_p[2]),
        .i_den (r_cacc_p[2]),
        .o_quo (w_q1x)
    );

    qarm_div #(.FRAC_BITS(FRAC_BITS)) u_div_ay (
        .i_clk (i_clk),
        .i_num (r_ay_p[2]),
        .i_den (r_cacc_p[2]),
        .o_quo (w_q1y)
    );

    always_ff @(posedge i_clk) begin
        // bank angle errors
        r_ex   <= f_sat32(64'(w_q1x) - 64'(r_r02_p[S_Q1]));
        r_ey   <= f_sat32(64'(w_q1y) - 64'(r_r12_p[S_Q1]));
        r_bx   <= f_mulq(w_bank_gain, r_ex);
        r_by   <= f_mulq(w_bank_gain, r_ey);
        // projection onto the body axes
        r_pa   <= f_mulq(r_r10_p[S_Q1+2], r_bx);
        r_pb   <= f_mulq(r_r00_p[S_Q1+2], r_by);
        r_pc   <= f_mulq(r_r11_p[S_Q1+2], r_bx);
        r_pd   <= f_mulq(r_r01_p[S_Q1+2], r_by);
        r_nump <= f_sat32(64'(r_pa) - 64'(r_pb));
        r_numq <= f_sat32(64'(r_pc) - 64'(r_pd));
    end

    // divide by r22
    qarm_div #(.FRAC_BITS(FRAC_BITS)) u_div_p (
        .i_clk (i_clk),
        .i_num (r_nump),
        .i_den (r_r22_p[S_NUM]),
        .o_quo (w_pc)
    );

    qarm_div #(.FRAC_BITS(FRAC_BITS)) u_div_q (
        .i_clk (i_clk),
        .i_num (r_numq),
        .i_den (r_r22_p[S_NUM]),
        .o_quo (w_qc)
    );

    always_ff @(posedge i_clk) begin
        r_pe <= f_sat32(64'(w_pc) - 64'(r_rp_p[S_Q2]));
        r_qe <= f_sat32(64'(w_qc) - 64'(r_rq_p[S_Q2]));
        r_mx <= f_mulq(w_mgain_x, r_pe);
        r_my <= f_mulq(w_mgain_y, r_qe);
        r_mp <= f_mulq(r_mx, w_arm_scale);
        r_mq <= f_mulq(r_my, w_arm_scale);
    end

    // ---------------------------------------------------------------- heading path
    // left half-plane vectors are turned by a quarter turn first
    always_comb begin
        n_cx = 36'(r_r00_p[2]);
        n_cy = 36'(r_r10_p[2]);
        n_cz = '0;
        if (r_r00_p[2] < 0) begin
            if (r_r10_p[2] >= 0) begin
                n_cx = 36'(r_r10_p[2]);
                n_cy = 36'sd0 - 36'(r_r00_p[2]);
                n_cz = HALF_PI_F;
            end else begin
                n_cx = 36'sd0 - 36'(r_r10_p[2]);
                n_cy = 36'(r_r00_p[2]);
                n_cz = 32'sd0 - HALF_PI_F;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[3]  <= n_cx;
        r_cy[3]  <= n_cy;
        r_cz[3]  <= n_cz;
        r_cnz[3] <= (r_r00_p[2] != '0) || (r_r10_p[2] != '0);
    end

    // one vectoring iteration per stage
    for (genvar gi = 0; gi < CORDIC_ITERS; gi++) begin : g_cordic
        localparam logic signed [31:0] ANG = 32'(f_q30_to_frac(f_atan_q30(gi), FRAC_BITS));
        always_ff @(posedge i_clk) begin
            if (r_cy[3+gi] > 0) begin
                r_cx[4+gi] <= r_cx[3+gi] + (r_cy[3+gi] >>> gi);
                r_cy[4+gi] <= r_cy[3+gi] - (r_cx[3+gi] >>> gi);
                r_cz[4+gi] <= r_cz[3+gi] + ANG;
            end else begin
                r_cx[4+gi] <= r_cx[3+gi] - (r_cy[3+gi] >>> gi);
                r_cy[4+gi] <= r_cy[3+gi] + (r_cx[3+gi] >>> gi);
                r_cz[4+gi] <= r_cz[3+gi] - ANG;
            end
            r_cnz[4+gi] <= r_cnz[3+gi];
        end
    end

    // zero vector gives zero yaw
    assign w_yaw = r_cnz[S_CZ] ? r_cz[S_CZ] : 32'sd0;
    assign n_err = 34'(r_ytgt_p[S_CZ]) - 34'(w_yaw);

    always_ff @(posedge i_clk) begin
        r_mm[S_ERR] <= n_err[33] ? 33'(34'sd0 - n_err) : n_err[32:0];
        r_ms[S_ERR] <= n_err[33];
    end

    // truncated remainder modulo 2*pi, sign follows the error
    for (genvar gj = 0; gj < MOD_ST; gj++) begin : g_mod
        always_ff @(posedge i_clk) begin
            r_mm[S_ERR+1+gj] <= f_mod_stage(r_mm[S_ERR+gj], gj);
            r_ms[S_ERR+1+gj] <= r_ms[S_ERR+gj];
        end
    end

    assign w_rem_mag = $signed(r_mm[S_MOD][31:0]);

    always_ff @(posedge i_clk) begin
        r_rem <= r_ms[S_MOD] ? (32'sd0 - w_rem_mag) : w_rem_mag;
        r_yc  <= f_mulq(w_heading_gain, r_rem);
        r_ye  <= f_sat32(64'(r_yc) - 64'(r_rr_p[S_MOD+2]));
        r_mz  <= f_mulq(w_mgain_z, r_ye);
        r_mr  <= f_sat32(64'sd0 - 64'(f_mulq(r_mz, w_drag_scale)));
    end

    // ---------------------------------------------------------------- x-frame mixer
    always_comb begin
        n_sum_fl = 34'(r_thr_p[S_MIX]) + 34'(r_mp) + 34'(r_mq) + 34'(r_mr);
        n_sum_fr = 34'(r_thr_p[S_MIX]) - 34'(r_mp) + 34'(r_mq) - 34'(r_mr);
        n_sum_rl = 34'(r_thr_p[S_MIX]) + 34'(r_mp) - 34'(r_mq) - 34'(r_mr);
        n_sum_rr = 34'(r_thr_p[S_MIX]) - 34'(r_mp) - 34'(r_mq) + 34'(r_mr);
    end

    always_ff @(posedge i_clk) begin
        if (r_flt_p[S_MIX]) begin
            r_tfl <= '0;
            r_tfr <= '0;
            r_trl <= '0;
            r_trr <= '0;
        end else begin
            // quarter share, floor, then saturate
            r_tfl <= f_sat32(64'(n_sum_fl >>> 2));
            r_tfr <= f_sat32(64'(n_sum_fr >>> 2));
            r_trl <= f_sat32(64'(n_sum_rl >>> 2));
            r_trr <= f_sat32(64'(n_sum_rr >>> 2));
        end
        r_fault <= r_flt_p[S_MIX];
    end

    assign o_done               = r_vld[LAT];
    assign o_thrust_front_left  = r_tfl;
    assign o_thrust_front_right = r_tfr;
    assign o_thrust_rear_left   = r_trl;
    assign o_thrust_rear_right  = r_trr;
    assign o_divide_fault       = r_fault;

    // ---------------------------------------------------------------- assertions
    // a faulted transaction carries zero thrust on every motor
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_divide_fault) |->
        (o_thrust_front_left == '0 && o_thrust_front_right == '0 &&
         o_thrust_rear_left == '0 && o_thrust_rear_right == '0))
        else $error("divide fault with non-zero thrust");

    // every accepted command gives its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("result strobe missing after pipeline latency");

    // a configuration write to the inverse mass register lands in it
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == REG_INV_MASS) |=>
        (r_inv_mass == $past(i_cfg_data[GAIN_W-1:0])))
        else $error("inverse mass register not updated");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for quad_attitude_rate_mixer_core: directed and random commands,
// a bit-exact predictor of the thrust mixer and a scoreboard; depends on qarm_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
    import qarm_pkg::*;

    localparam int FRAC      = 16;
    localparam int NUM_CFG   = 8;
    localparam int LAT_WAIT  = 60;     // drain wait, covers the result latency with margin

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] thrust;
        logic signed [31:0] qw;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic signed [31:0] rp;
        logic signed [31:0] rq;
        logic signed [31:0] rr;
        logic signed [31:0] yaw_tgt;
    } t_command;

    typedef struct packed {
        logic signed [31:0] fl;
        logic signed [31:0] fr;
        logic signed [31:0] rl;
        logic signed [31:0] rr;
        logic               fault;
    } t_motor_set;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_command cmd = '0;
    logic o_done;
    t_motor_set got;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor copy of the gain registers
    logic [30:0] gain_reg [NUM_CFG];

    t_command   pending_cmds[$];
    t_motor_set expected_thrusts[$];
    int  send_idle_pct = 0;
    bit  hold_send = 1'b0;
    bit  failed = 1'b0;

    always #6 i_clk = ~i_clk;

    quad_attitude_rate_mixer_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy),
        .i_accel_x_cmd(cmd.accel_x), .i_accel_y_cmd(cmd.accel_y),
        .i_coll_thrust(cmd.thrust),
        .i_quat_w(cmd.qw), .i_quat_x(cmd.qx), .i_quat_y(cmd.qy), .i_quat_z(cmd.qz),
        .i_rate_p(cmd.rp), .i_rate_q(cmd.rq), .i_rate_r(cmd.rr),
        .i_yaw_target(cmd.yaw_tgt),
        .o_done(o_done),
        .o_thrust_front_left(got.fl), .o_thrust_front_right(got.fr),
        .o_thrust_rear_left(got.rl), .o_thrust_rear_right(got.rr),
        .o_divide_fault(got.fault),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // ---------------- fixed point arithmetic of the controller ----------------

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // product with floor rounding then saturation
    function automatic longint fx_mul(input longint a, input longint b);
        return clamp32((a * b) >>> FRAC);
    endfunction

    // quotient truncated toward zero, zero divisor gives zero
    function automatic longint fx_div(input longint a, input longint b);
        if (b == 0) return 0;
        return clamp32((a * (longint'(1) <<< FRAC)) / b);
    endfunction

    function automatic longint q30_round(input longint v);
        return (v + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    // vectoring cordic heading of (x, y)
    function automatic longint heading_of(input longint vx, input longint vy);
        longint ang, t, step, dx, dy;
        longint atab [11];
        atab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                 16775851, 8388437, 4194283, 2097149, 1048576};
        ang = 0;
        if (vx == 0 && vy == 0) return 0;
        // left half-plane: rotate by a quarter turn first
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx = vy; vy = -t; ang = q30_round(1686629713);
            end else begin
                vx = -vy; vy = t; ang = -q30_round(1686629713);
            end
        end
        for (int i = 0; i < 24; i++) begin
            step = q30_round(i < 11 ? atab[i] : (longint'(1) <<< (30 - i)));
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx += dx; vy -= dy; ang += step;
            end else begin
                vx -= dx; vy += dy; ang -= step;
            end
        end
        return ang;
    endfunction

    function automatic t_motor_set mix_thrusts(input t_command c);
        t_motor_set m;
        longint w, x, y, z, thr;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint r00, r01, r02, r10, r11, r12, r22;
        longint cacc, bx, by, pc, qc, yc, err, two_pi;
        longint mx, my, mz, mp, mq, mr;
        w = c.qw; x = c.qx; y = c.qy; z = c.qz; thr = c.thrust;
        xx = fx_mul(x, x); yy = fx_mul(y, y); zz = fx_mul(z, z);
        xy = fx_mul(x, y); xz = fx_mul(x, z); yz = fx_mul(y, z);
        wx = fx_mul(w, x); wy = fx_mul(w, y); wz = fx_mul(w, z);
        r00 = clamp32(65536 - 2 * (yy + zz));
        r01 = clamp32(2 * (xy - wz));
        r02 = clamp32(2 * (xz + wy));
        r10 = clamp32(2 * (xy + wz));
        r11 = clamp32(65536 - 2 * (xx + zz));
        r12 = clamp32(2 * (yz - wx));
        r22 = clamp32(65536 - 2 * (xx + yy));
        cacc = clamp32(-fx_mul(thr, longint'(gain_reg[REG_INV_MASS])));
        m = '0;
        if (cacc == 0 || r22 == 0) begin
            m.fault = 1'b1;
            return m;
        end
        bx = fx_mul(gain_reg[REG_BANK_GAIN], clamp32(fx_div(c.accel_x, cacc) - r02));
        by = fx_mul(gain_reg[REG_BANK_GAIN], clamp32(fx_div(c.accel_y, cacc) - r12));
        pc = fx_div(clamp32(fx_mul(r10, bx) - fx_mul(r00, by)), r22);
        qc = fx_div(clamp32(fx_mul(r11, bx) - fx_mul(r01, by)), r22);
        // yaw error: truncated remainder, not folded
        two_pi = q30_round(64'sd6746518852);
        err = longint'(c.yaw_tgt) - heading_of(r00, r10);
        yc = fx_mul(gain_reg[REG_HEADING_GAIN], err % two_pi);
        mx = fx_mul(gain_reg[REG_MGAIN_X], clamp32(pc - longint'(c.rp)));
        my = fx_mul(gain_reg[REG_MGAIN_Y], clamp32(qc - longint'(c.rq)));
        mz = fx_mul(gain_reg[REG_MGAIN_Z], clamp32(yc - longint'(c.rr)));
        mp = fx_mul(mx, gain_reg[REG_ARM_SCALE]);
        mq = fx_mul(my, gain_reg[REG_ARM_SCALE]);
        mr = clamp32(-fx_mul(mz, gain_reg[REG_DRAG_SCALE]));
        m.fl = clamp32((thr + mp + mq + mr) >>> 2);
        m.fr = clamp32((thr - mp + mq - mr) >>> 2);
        m.rl = clamp32((thr + mp - mq - mr) >>> 2);
        m.rr = clamp32((thr - mp - mq + mr) >>> 2);
        return m;
    endfunction

    // ---------------- driver ----------------
    // a transaction is taken at an edge with start high and busy low
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_thrusts.push_back(mix_thrusts(cmd));
            end
            if ((!start || !busy) && pending_cmds.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
                cmd <= pending_cmds.pop_front();
                start <= 1'b1;
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_motor_set exp_m;
        if (i_rst_n && o_done) begin
            if (expected_thrusts.size() == 0) begin
                $error("unexpected result transaction");
                failed = 1'b1;
            end else begin
                exp_m = expected_thrusts.pop_front();
                if (got.fl !== exp_m.fl) begin
                    $error("thrust_front_left exp %0d got %0d", exp_m.fl, got.fl);
                    failed = 1'b1;
                end
                if (got.fr !== exp_m.fr) begin
                    $error("thrust_front_right exp %0d got %0d", exp_m.fr, got.fr);
                    failed = 1'b1;
                end
                if (got.rl !== exp_m.rl) begin
                    $error("thrust_rear_left exp %0d got %0d", exp_m.rl, got.rl);
                    failed = 1'b1;
                end
                if (got.rr !== exp_m.rr) begin
                    $error("thrust_rear_right exp %0d got %0d", exp_m.rr, got.rr);
                    failed = 1'b1;
                end
                if (got.fault !== exp_m.fault) begin
                    $error("divide_fault exp %0d got %0d", exp_m.fault, got.fault);
                    failed = 1'b1;
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    // wait until the pipeline has drained
    task automatic drain();
        while (pending_cmds.size() > 0 || start || expected_thrusts.size() > 0)
            @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < NUM_CFG) gain_reg[idx] = val[30:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // unit-ish quaternion components most of the time so the loops do real work
    function automatic logic signed [31:0] near_unit();
        if ($urandom_range(9) == 0) return rnd_word();
        return $signed(32'($urandom_range(131072))) - 32'sd65536;
    endfunction

    function automatic t_command rnd_command();
        t_command c;
        c.qw = near_unit(); c.qx = near_unit() >>> 2;
        c.qy = near_unit() >>> 2; c.qz = near_unit();
        c.thrust  = ($urandom_range(15) == 0) ? rnd_word()
                  : $signed(32'($urandom_range(2000000))) - 32'sd200000;
        c.accel_x = ($urandom_range(3) == 0) ? rnd_word() : $signed(32'($urandom)) >>> 12;
        c.accel_y = ($urandom_range(3) == 0) ? rnd_word() : $signed(32'($urandom)) >>> 12;
        c.rp = ($urandom_range(3) == 0) ? rnd_word() : $signed(32'($urandom)) >>> 12;
        c.rq = ($urandom_range(3) == 0) ? rnd_word() : $signed(32'($urandom)) >>> 12;
        c.rr = ($urandom_range(3) == 0) ? rnd_word() : $signed(32'($urandom)) >>> 12;
        c.yaw_tgt = ($urandom_range(3) == 0) ? rnd_word() : $signed(32'($urandom)) >>> 11;
        return c;
    endfunction

    function automatic logic [31:0] rnd_gain();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return '0;
            2: return 32'hFFFF_FFFF;   // bit 31 must be dropped
            default: return 32'($urandom_range(200000));
        endcase
    endfunction

    // ---------------- main sequence ----------------
    initial begin
        t_command c;
        for (int i = 0; i < NUM_CFG; i++)
            gain_reg[i] = (i >= REG_INV_MASS) ? GAIN_RST_ONE : GAIN_RST_ZERO;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset gains, hover, zero thrust, zero r22, extremes
        c = '0; c.qw = 32'sd65536; c.thrust = 32'sd655360;
        pending_cmds.push_back(c);
        c.thrust = '0; pending_cmds.push_back(c);
        c.thrust = -32'sd655360; pending_cmds.push_back(c);
        drain();
        write_gain(REG_BANK_GAIN, 32'd131072);
        write_gain(REG_HEADING_GAIN, 32'd65536);
        write_gain(REG_MGAIN_X, 32'd32768);
        write_gain(REG_MGAIN_Y, 32'd32768);
        write_gain(REG_MGAIN_Z, 32'd16384);
        write_gain(REG_INV_MASS, 32'd40000);
        write_gain(REG_ARM_SCALE, 32'd92682);
        write_gain(REG_DRAG_SCALE, 32'd300000);
        write_gain(8'd9, 32'hFFFF_FFFF);   // beyond the register list
        c = '0; c.qw = 32'sd65536; c.thrust = 32'sd655360; c.yaw_tgt = 32'sd300000;
        c.rp = 32'sd1000; c.accel_x = 32'sd20000;
        pending_cmds.push_back(c);
        c.qx = 32'sd46341; c.qw = 32'sd46341;     // r22 becomes zero
        pending_cmds.push_back(c);
        c.qx = '0; c.qw = '0; c.qz = 32'sd65536;  // heading at pi, left half-plane
        pending_cmds.push_back(c);
        c.qw = 32'sd1;  c.qz = 32'sd1;            // tiny qw and qz, heading vector along x
        pending_cmds.push_back(c);
        c.qz = 32'sd46341; c.qw = -32'sd46341;    // negative heading
        c.yaw_tgt = 32'sh7FFF_FFFF;
        pending_cmds.push_back(c);
        c.yaw_tgt = 32'sh8000_0000; c.thrust = 32'sh7FFF_FFFF;
        c.accel_x = 32'sh8000_0000; c.accel_y = 32'sh7FFF_FFFF;
        c.rp = 32'sh8000_0000; c.rq = 32'sh7FFF_FFFF; c.rr = 32'sh8000_0000;
        pending_cmds.push_back(c);
        c.thrust = 32'sh8000_0000; c.qx = 32'sh7FFF_FFFF; c.qy = 32'sh8000_0000;
        pending_cmds.push_back(c);
        c = '1; pending_cmds.push_back(c);
        c = '0; c.thrust = 32'sd1; c.qw = 32'sd65536;   // thrust underflows to zero
        pending_cmds.push_back(c);
        drain();

        // random phases with new gains each time, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: send_idle_pct = 0;
                1: send_idle_pct = 78;
                2: send_idle_pct = 0;
                default: send_idle_pct = 29;
            endcase
            for (int r = 0; r < NUM_CFG; r++) begin
                if (ph == 3) write_gain(CFG_IDX_W'(r), 32'h7FFF_FFFF);
                else if (ph == 5) write_gain(CFG_IDX_W'(r),
                                             (r >= REG_INV_MASS) ? 32'd65536 : 32'd0);
                else write_gain(CFG_IDX_W'(r), rnd_gain());
            end
            for (int n = 0; n < 68; n++) pending_cmds.push_back(rnd_command());
            if (ph == 2) begin
                // sender holds off until everything outstanding has come back
                while (pending_cmds.size() > 34) @(posedge i_clk);
                hold_send = 1'b1;
                while (expected_thrusts.size() > 0 || start) @(posedge i_clk);
                hold_send = 1'b0;
            end
            drain();
        end

        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // timeout guard
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
